@@ rtl/cset_pkg.sv @@
// shared types and constants of the config space enumerator table
`timescale 1ns / 1ps
`default_nettype none
package cset_pkg;
  localparam int unsigned TableDepthDefault = 128;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_READ  = 3'd1,
    CMD_CLASS = 3'd2,
    CMD_VDID  = 3'd3,
    CMD_INDEX = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_HIT  = 2'd2,
    KIND_MISS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ID0  = 3'd1,
    PH_HDR  = 3'd2,
    PH_CLS  = 3'd3,
    PH_IDN  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT,
    ST_CHECK,
    ST_OUT
  } state_e;

  localparam logic [7:0] OffId  = 8'h00;
  localparam logic [7:0] OffCls = 8'h08;
  localparam logic [7:0] OffHdr = 8'h0C;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] read_dword;
    logic [7:0]  class_key;
    logic [7:0]  subclass_key;
    logic [15:0] vendor_key;
    logic [15:0] device_key;
    logic [6:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cfg_address;
    logic [7:0]  found_bus;
    logic [4:0]  found_slot;
    logic [2:0]  found_function;
    logic [15:0] found_vendor;
    logic [15:0] found_device;
    logic [7:0]  found_revision;
    logic [7:0]  found_interface;
    logic [7:0]  found_subclass;
    logic [7:0]  found_class;
    logic [7:0]  entries_held;
  } out_word_t;
endpackage
`default_nettype wire

@@ rtl/cset_if.sv @@
// valid/ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface cset_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cset_table.sv @@
// entry memory: 80-bit rows, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module cset_table #(
  parameter int unsigned AW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [79:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [79:0]   rdata_o
);
  logic [79:0] mem [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/config_space_enumerator_table_core.sv @@
// top level: pci bus scan sequencer with lookup over the entry memory
// scan steps: a result is registered and shown next cycle; input waits until it is taken
// a lookup walks the entries in three steps each (address, read wait, compare);
// a lookup by index skips the address step
// reset clears the sequencer, scan position and entry count; the memory
// holds garbage until written, and a row is only reported below the entry count
`timescale 1ns / 1ps
`default_nettype none
module config_space_enumerator_table_core #(
  parameter int unsigned TABLE_DEPTH = cset_pkg::TableDepthDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cset_if.sink     in_i,
  cset_if.source   out_o
);
  import cset_pkg::*;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0] bus_q, bus_d;
  logic [4:0] slot_q, slot_d;
  logic [2:0] fn_q, fn_d;
  logic multi_q, multi_d;
  logic [31:0] ids_q, ids_d;
  in_word_t cmd_q, cmd_d;       // held lookup word
  logic [CW-1:0] idx_q, idx_d;  // lookup walk position
  out_word_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [79:0] wdata, rdata;
  // row: bus, slot, fn, device, vendor, class dword
  cset_table #(.AW(AW)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic full;
  assign full = (count_q >= CW'(TABLE_DEPTH));
  assign in_i.ready = (state_q == ST_IDLE) && !res_valid_q;
  assign out_o.valid = res_valid_q;
  assign out_o.data = res_q;

  logic accept;
  assign accept = in_i.valid && in_i.ready;

  // hit fields from a memory row
  function automatic out_word_t hit_word(logic [79:0] r, logic [7:0] held);
    out_word_t o;
    o = '0;
    o.kind = KIND_HIT;
    o.found_bus = r[79:72];
    o.found_slot = r[71:67];
    o.found_function = r[66:64];
    o.found_vendor = r[47:32];
    o.found_device = r[63:48];
    o.found_revision = r[7:0];
    o.found_interface = r[15:8];
    o.found_subclass = r[23:16];
    o.found_class = r[31:24];
    o.entries_held = held;
    return o;
  endfunction

  logic [7:0] held8;
  assign held8 = 8'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
      count_q <= '0;
      bus_q <= '0;
      slot_q <= '0;
      fn_q <= '0;
      multi_q <= 1'b0;
      ids_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      bus_q <= bus_d;
      slot_q <= slot_d;
      fn_q <= fn_d;
      multi_q <= multi_d;
      ids_q <= ids_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.data.cmd == CMD_CLASS || in_i.data.cmd == CMD_VDID) begin
            state_d = ST_SEARCH;
          end else if (in_i.data.cmd == CMD_INDEX) begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_SEARCH: state_d = (idx_q >= count_q) ? ST_OUT : ST_WAIT;
      ST_WAIT: state_d = ST_CHECK;
      ST_CHECK: state_d = ST_SEARCH;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_CHECK && cmd_q.cmd != CMD_INDEX) begin
      if ((cmd_q.cmd == CMD_CLASS && rdata[31:24] == cmd_q.class_key &&
           rdata[23:16] == cmd_q.subclass_key) ||
          (cmd_q.cmd == CMD_VDID && rdata[47:32] == cmd_q.vendor_key &&
           rdata[63:48] == cmd_q.device_key)) begin
        state_d = ST_IDLE;
      end
    end else if (state_q == ST_CHECK) begin
      state_d = ST_IDLE;
    end
  end

  // outputs and datapath
  always_comb begin
    logic [7:0] off;
    logic emit_req;
    logic adv;
    phase_d = phase_q;
    count_d = count_q;
    bus_d = bus_q;
    slot_d = slot_q;
    fn_d = fn_q;
    multi_d = multi_q;
    ids_d = ids_q;
    cmd_d = cmd_q;
    idx_d = idx_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !out_o.ready;
    we = 1'b0;
    waddr = AW'(count_q);
    wdata = {bus_q, slot_q, fn_q, ids_q, in_i.data.read_dword};
    raddr = AW'(idx_q);
    off = OffId;
    emit_req = 1'b0;
    adv = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = in_i.data;
          idx_d = '0;
          case (in_i.data.cmd)
            CMD_START: begin
              count_d = '0;
              bus_d = '0;
              slot_d = '0;
              fn_d = '0;
              multi_d = 1'b0;
              ids_d = '0;
              phase_d = PH_ID0;
              off = OffId;
              emit_req = 1'b1;
            end
            CMD_READ: begin
              unique case (phase_q)
                PH_ID0: begin
                  if (in_i.data.read_dword[15:0] == 16'hFFFF) begin
                    multi_d = 1'b0;
                    adv = 1'b1;
                  end else begin
                    ids_d = in_i.data.read_dword;
                    phase_d = PH_HDR;
                    off = OffHdr;
                    emit_req = 1'b1;
                  end
                end
                PH_HDR: begin
                  multi_d = in_i.data.read_dword[23];
                  if (!full) begin
                    phase_d = PH_CLS;
                    off = OffCls;
                    emit_req = 1'b1;
                  end else begin
                    adv = 1'b1;
                  end
                end
                PH_IDN: begin
                  if (in_i.data.read_dword[15:0] == 16'hFFFF) begin
                    adv = 1'b1;
                  end else begin
                    ids_d = in_i.data.read_dword;
                    if (!full) begin
                      phase_d = PH_CLS;
                      off = OffCls;
                      emit_req = 1'b1;
                    end else begin
                      adv = 1'b1;
                    end
                  end
                end
                PH_CLS: begin
                  if (!full) begin
                    we = 1'b1;
                    count_d = count_q + 1'b1;
                  end
                  adv = 1'b1;
                end
                default: ;
              endcase
            end
            CMD_INDEX: begin
              idx_d = CW'(in_i.data.entry_index);
              raddr = AW'(in_i.data.entry_index);
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (idx_q >= count_q) begin
          res_d = '0;
          res_d.kind = KIND_MISS;
          res_d.entries_held = held8;
        end
      end
      ST_CHECK: begin
        if (cmd_q.cmd == CMD_INDEX) begin
          res_d = hit_word(rdata, held8);
          if ({1'b0, idx_q} >= {1'b0, count_q} ||
              cmd_q.entry_index >= 7'(TABLE_DEPTH > 127 ? 127 : TABLE_DEPTH) &&
              TABLE_DEPTH <= 127) begin
            res_d = '0;
            res_d.kind = KIND_MISS;
            res_d.entries_held = held8;
          end
          res_valid_d = 1'b1;
        end else if ((cmd_q.cmd == CMD_CLASS && rdata[31:24] == cmd_q.class_key &&
                      rdata[23:16] == cmd_q.subclass_key) ||
                     (cmd_q.cmd == CMD_VDID && rdata[47:32] == cmd_q.vendor_key &&
                      rdata[63:48] == cmd_q.device_key)) begin
          res_d = hit_word(rdata, held8);
          res_valid_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_OUT: res_valid_d = 1'b1;
      default: ;
    endcase

    // step to the next function, slot or bus
    if (adv) begin
      if (multi_d && fn_q != 3'd7) begin
        fn_d = fn_q + 3'd1;
        phase_d = PH_IDN;
        emit_req = 1'b1;
        off = OffId;
      end else begin
        fn_d = '0;
        multi_d = 1'b0;
        slot_d = slot_q + 5'd1;
        if (slot_q == 5'd31) begin
          bus_d = bus_q + 8'd1;
        end
        if (slot_q == 5'd31 && bus_q == 8'd255) begin
          phase_d = PH_IDLE;
          res_d = '0;
          res_d.kind = KIND_DONE;
          res_d.entries_held = 8'(count_d);
          res_valid_d = 1'b1;
        end else begin
          phase_d = PH_ID0;
          emit_req = 1'b1;
          off = OffId;
        end
      end
    end
    if (emit_req) begin
      res_d = '0;
      res_d.kind = KIND_REQ;
      res_d.cfg_address = {1'b1, 7'd0, bus_d, slot_d, fn_d, off & 8'hFC};
      res_d.entries_held = 8'(count_d);
      res_valid_d = 1'b1;
    end
  end
endmodule
`default_nettype wire
